### sv/trial_division_prime_test_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trial-division prime test
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// A property checked on every rising edge while reset is released.
`define TDPT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold while reset is released.
`define TDPT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `TDPT_ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

### sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial-division prime test package
// Shared constants and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

  // Default width of the tested value.
  localparam int VALUE_BITS_DEF = 31;

  // Constants of the 6k +/- 1 scheme.
  localparam int FIRST_DIVISOR = 5;
  localparam int DIVISOR_STEP  = 6;
  localparam int PAIR_GAP      = 2;
  localparam int SMALL_PRIME   = 3;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BOUND = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Which remainder the shared divider is working on.
  typedef enum logic [1:0] {
    P_THREE = 2'd0,
    P_LOW   = 2'd1,
    P_HIGH  = 2'd2
  } phase_t;

endpackage

`default_nettype wire

### sv/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial-division prime test
// Answers whether an unsigned number is prime using 6k +/- 1 trial division.
// ----------------------------------------------------------------------------
// A request arrives on in_valid/in_ready carrying in_number. Exactly one
// result leaves on out_valid/out_ready, with out_is_prime high for a prime.
// One request is handled at a time: in_ready is low from acceptance until
// the result has been taken, and high again in the cycle after that.
// Values up to 3 and even values are settled at once, so the result can be
// taken in the cycle after acceptance. Otherwise one shared restoring
// divider, one quotient bit per cycle, works out each remainder: first
// modulo 3, then per pair d, d+2 (d = 5, 11, 17, ...) a bound check
// against a running square and two remainders. A 31-bit prime near the
// top of the range needs about 7700 pairs. Reset (rst_n low, synchronous)
// returns the controller to idle and drops a pending result. A stalled
// receiver sees the result held on out_is_prime with out_valid high, and
// no request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test #(
  parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_is_prime
);

  // A divisor never exceeds about the square root of the value plus a step.
  localparam int DW    = VALUE_BITS / 2 + 3;
  // The running square may pass the value by one step before the loop ends.
  localparam int SQ_W  = VALUE_BITS + 2;
  localparam int CNT_W = $clog2(VALUE_BITS);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
  localparam logic [DW-1:0]    D_FIRST  = DW'(tdpt_pkg::FIRST_DIVISOR);
  localparam logic [DW-1:0]    D_STEP   = DW'(tdpt_pkg::DIVISOR_STEP);
  localparam logic [DW-1:0]    D_GAP    = DW'(tdpt_pkg::PAIR_GAP);
  localparam logic [DW-1:0]    D_THREE  = DW'(tdpt_pkg::SMALL_PRIME);
  localparam logic [SQ_W-1:0]  SQ_FIRST =
    SQ_W'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
  // (d + 6)^2 = d^2 + 12 d + 36
  localparam logic [SQ_W-1:0]  SQ_CONST =
    SQ_W'(tdpt_pkg::DIVISOR_STEP * tdpt_pkg::DIVISOR_STEP);

  tdpt_pkg::state_t state_r, state_nxt;
  tdpt_pkg::phase_t phase_r, phase_nxt;

  logic [VALUE_BITS-1:0] v_r, v_nxt;       // value under test
  logic [VALUE_BITS-1:0] sh_r, sh_nxt;     // dividend bits, MSB first
  logic [DW-1:0]         rem_r, rem_nxt;   // partial remainder
  logic [DW-1:0]         div_r, div_nxt;   // current divisor
  logic [DW-1:0]         d_r, d_nxt;       // low divisor of the pair
  logic [SQ_W-1:0]       sq_r, sq_nxt;     // d_r squared
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;   // quotient bits left after the current one
  logic                  res_r, res_nxt;   // result bit

  // Shared divider step: shift in one dividend bit, subtract if it fits.
  logic [DW:0]   shift_w;
  logic [DW:0]   trial_w;
  logic [DW-1:0] rem_step;
  logic [SQ_W-1:0] d_ext;

  always_comb begin
    shift_w  = {rem_r, sh_r[VALUE_BITS-1]};
    trial_w  = shift_w - {1'b0, div_r};
    rem_step = (shift_w >= {1'b0, div_r}) ? trial_w[DW-1:0] : shift_w[DW-1:0];
    d_ext    = SQ_W'(d_r);
  end

  assign in_ready     = (state_r == tdpt_pkg::S_IDLE);
  assign out_valid    = (state_r == tdpt_pkg::S_DONE);
  assign out_is_prime = res_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    v_nxt     = v_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;

    unique case (state_r)
      tdpt_pkg::S_IDLE: begin
        if (in_valid) begin
          v_nxt = in_number;
          // Small values and even values are settled without dividing.
          priority if (in_number <= VALUE_BITS'(1)) begin
            res_nxt   = 1'b0;
            state_nxt = tdpt_pkg::S_DONE;
          end else if (in_number <= VALUE_BITS'(tdpt_pkg::SMALL_PRIME)) begin
            res_nxt   = 1'b1;
            state_nxt = tdpt_pkg::S_DONE;
          end else if (!in_number[0]) begin
            res_nxt   = 1'b0;
            state_nxt = tdpt_pkg::S_DONE;
          end else begin
            phase_nxt = tdpt_pkg::P_THREE;
            div_nxt   = D_THREE;
            sh_nxt    = in_number;
            rem_nxt   = '0;
            cnt_nxt   = CNT_LAST;
            d_nxt     = D_FIRST;
            sq_nxt    = SQ_FIRST;
            state_nxt = tdpt_pkg::S_DIV;
          end
        end
      end

      tdpt_pkg::S_BOUND: begin
        if (sq_r > {2'b00, v_r}) begin
          // No divisor up to the square root: the value is prime.
          res_nxt   = 1'b1;
          state_nxt = tdpt_pkg::S_DONE;
        end else begin
          phase_nxt = tdpt_pkg::P_LOW;
          div_nxt   = d_r;
          sh_nxt    = v_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_LAST;
          state_nxt = tdpt_pkg::S_DIV;
        end
      end

      tdpt_pkg::S_DIV: begin
        rem_nxt = rem_step;
        sh_nxt  = {sh_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (rem_step == '0) begin
            res_nxt   = 1'b0;
            state_nxt = tdpt_pkg::S_DONE;
          end else begin
            unique case (phase_r)
              tdpt_pkg::P_THREE: begin
                state_nxt = tdpt_pkg::S_BOUND;
              end
              tdpt_pkg::P_LOW: begin
                phase_nxt = tdpt_pkg::P_HIGH;
                div_nxt   = d_r + D_GAP;
                sh_nxt    = v_r;
                rem_nxt   = '0;
                cnt_nxt   = CNT_LAST;
              end
              tdpt_pkg::P_HIGH: begin
                d_nxt     = d_r + D_STEP;
                sq_nxt    = sq_r + (d_ext << 3) + (d_ext << 2) + SQ_CONST;
                state_nxt = tdpt_pkg::S_BOUND;
              end
              default: begin
                state_nxt = tdpt_pkg::S_BOUND;
              end
            endcase
          end
        end
      end

      tdpt_pkg::S_DONE: begin
        if (out_ready) begin
          state_nxt = tdpt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tdpt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdpt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    v_r     <= v_nxt;
    sh_r    <= sh_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire

### sv/tdpt_checker.sv
// ----------------------------------------------------------------------------
// Trial-division prime test checker
// Port-level assertions on the request and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trial_division_prime_test_macros.svh"

module tdpt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_is_prime
);

  `TDPT_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_is_prime), "result changed or dropped while stalled")

  `TDPT_ASSERT_NEVER(a_one_at_a_time, clk, rst_n, in_ready && out_valid, "request taken while a result is pending")

  `TDPT_ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "second request taken while busy")

  `TDPT_ASSERT_CLK(a_ready_after_result, clk, rst_n, out_valid && out_ready |=> in_ready && !out_valid, "block not idle after result taken")

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

`default_nettype wire

### bench/trial_division_prime_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the trial-division prime test
// Sends corner values and random numbers through the valid/ready request
// channel and checks every verdict against a primality predictor in the
// bench. The sender works in bursts and the receiver stalls on a pattern of
// its own, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------

module trial_division_prime_test_tb;

  localparam int          NUM_BITS     = tdpt_pkg::VALUE_BITS_DEF;
  localparam int unsigned TOP_VALUE    = (32'd1 << NUM_BITS) - 1;
  localparam int          RANDOM_COUNT = 80;
  // The slowest request, a prime near the top of the range, must finish
  // within the watchdog limit without a single handshake.
  localparam int          IDLE_LIMIT   = 2000000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          HOLD_AFTER   = 30;
  localparam int          DRAIN_CYCLES = 2 * NUM_BITS + 8;

  // --------------------------------------------------------------------------
  // Verdict checker: predicts the answer for each accepted request and
  // compares the answers that come back, oldest first.
  // --------------------------------------------------------------------------
  class verdict_checker;

    typedef struct {
      logic [NUM_BITS-1:0] number;
      bit                  verdict;
    } verdict_t;

    verdict_t    pending_verdicts[$];
    int unsigned requests;
    int unsigned answers;
    int unsigned primes;
    int unsigned errors;

    // 6k +/- 1 trial division, done in 64-bit arithmetic so the bound
    // d * d cannot wrap.
    function bit prime_verdict(logic [NUM_BITS-1:0] number);
      longint unsigned v;
      longint unsigned d;
      v = 64'(number);
      if (v <= 1) return 1'b0;
      if (v <= tdpt_pkg::SMALL_PRIME) return 1'b1;
      if (v % tdpt_pkg::PAIR_GAP == 0 || v % tdpt_pkg::SMALL_PRIME == 0) return 1'b0;
      for (d = tdpt_pkg::FIRST_DIVISOR; d * d <= v; d += tdpt_pkg::DIVISOR_STEP) begin
        if (v % d == 0 || v % (d + tdpt_pkg::PAIR_GAP) == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic [NUM_BITS-1:0] number);
      verdict_t entry;
      entry.number  = number;
      entry.verdict = prime_verdict(number);
      pending_verdicts = {pending_verdicts, entry};
      requests++;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_verdict(logic got);
      verdict_t entry;
      answers++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("answer %0b arrived with no request waiting", got));
      end else begin
        entry = pending_verdicts.pop_front();
        if (entry.verdict) primes++;
        if (got !== entry.verdict)
          report_mismatch($sformatf("number %0d: is_prime %0b, expected %0b",
                                    entry.number, got, entry.verdict));
      end
    endtask

    function int pending();
      return pending_verdicts.size();
    endfunction

  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test. Every input starts at a known
  // value so nothing is undefined before reset is released.
  // --------------------------------------------------------------------------
  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic [NUM_BITS-1:0] in_number    = '0;
  logic                out_ready    = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic                out_is_prime;

  always #2 clk = ~clk;

  trial_division_prime_test #(
    .VALUE_BITS (NUM_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime)
  );

  verdict_checker verdict_chk = new;

  // Small primes used to build large composites that the block rejects
  // after only a handful of divisor pairs.
  int unsigned small_primes[$] = {3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 97};

  // Corner values: zero and one, the two small primes, the first multiples
  // of two and three, squares and products that land on each member of a
  // divisor pair, the largest value (itself a prime, the slowest request),
  // the largest even value, a lone top bit and alternating bit patterns.
  int unsigned corner_numbers[$] = {
    0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 35, 49, 97, 121, 143, 65521,
    TOP_VALUE, TOP_VALUE - 1, TOP_VALUE - 2, TOP_VALUE - 4,
    32'h4000_0000, 32'h5555_5555 & TOP_VALUE, 32'h2AAA_AAAA
  };

  int unsigned burst_left = 0;

  // --------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge, before the
  // nonblocking updates of that edge take effect.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) verdict_chk.note_request(in_number);
      if (out_valid && out_ready) verdict_chk.check_verdict(out_is_prime);
    end
  end

  // Watchdog: ends the run if no request moves on either channel for too
  // long.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Requests go out in bursts; between bursts valid may drop for a
  // random gap. Within a burst valid stays high and only the number changes,
  // so valid is never lowered and raised in the same time step.
  // --------------------------------------------------------------------------
  task send_number(input logic [NUM_BITS-1:0] number);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 6);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Most random numbers are small, so the divider loop stays short; the rest
  // span the whole width but carry a small factor, so they finish quickly.
  function automatic logic [NUM_BITS-1:0] random_number();
    int unsigned factor;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 4) return NUM_BITS'($urandom_range(0, 1023));
    if (pick <= 7) return NUM_BITS'($urandom_range(1024, 65535));
    factor = small_primes[$urandom_range(0, small_primes.size() - 1)];
    return NUM_BITS'(factor * $urandom_range(1, TOP_VALUE / factor));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver. Readiness walks an 8-bit pattern, redrawn when beat is a
  // multiple of 32; one draw in four is all-ready. Once, after a few dozen
  // requests, it holds off for a long stretch while the sender keeps
  // offering, so the block holds its answer and stalls its input.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned beat;
    logic [7:0]  pattern;
    bit          held;
    beat    = 0;
    pattern = 8'hFF;
    held    = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && verdict_chk.requests >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (beat % 32 == 0) begin
          case ($urandom_range(0, 3))
            0:       pattern = 8'hFF;
            1:       pattern = 8'($urandom);
            default: pattern = 8'($urandom | $urandom);
          endcase
        end
        out_ready <= pattern[beat % 8];
        beat++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the corner values, the random part, then drain.
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_numbers[i]) send_number(NUM_BITS'(corner_numbers[i]));
    repeat (RANDOM_COUNT) send_number(random_number());
    in_valid <= 1'b0;

    // Let the monitor note the last request, then wait
    // for every answer and a little longer to catch any extra one.
    @(posedge clk);
    while (verdict_chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d corner values, %0d random) and %0d answers.",
             verdict_chk.requests, corner_numbers.size(), RANDOM_COUNT, verdict_chk.answers);
    $display("Primes among them: %0d; mismatches: %0d.",
             verdict_chk.primes, verdict_chk.errors);
    if (verdict_chk.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
